// ===== design/kdt_pkg.sv =====
`timescale 1ns / 1ps
package kdt_pkg;
  localparam int DEPTH_DEF = 64;
  localparam int KEY_W = 16;
  localparam int PRICE_W = 24;
  localparam int QTY_W = 32;
  localparam int COUNT_W = 7;
  localparam int ENTRY_W = KEY_W + PRICE_W + QTY_W;

  localparam logic [2:0] ACT_PUSH_BACK  = 3'd0;
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_FIND       = 3'd4;
  localparam logic [2:0] ACT_REMOVE     = 3'd5;
  localparam logic [2:0] ACT_UPDATE     = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
endpackage

// ===== design/kdt_store.sv =====
`timescale 1ns / 1ps
module kdt_store #(
  parameter int DEPTH = kdt_pkg::DEPTH_DEF,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [kdt_pkg::ENTRY_W-1:0] wr_data,
  input  logic [AW-1:0]              rd_addr,
  output logic [kdt_pkg::ENTRY_W-1:0] rd_data
);
  logic [kdt_pkg::ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== design/keyed_deque_table_core.sv =====
`timescale 1ns / 1ps
// Channel | Ports                                         | Direction
// input   | start, busy, in_action/key/price/quantity     | in (busy out)
// result  | out_valid, out_status/entry_*                 | out
// Push writes the store in its dispatch state. Pop, find, update and remove
// read the store through its registered read port; find, update and remove
// scan from the front, and remove then shifts each later entry one place
// toward the front, with one read and one write per entry moved.
// Synchronous active-low reset clears head and count, sets the key counter to
// 1 and holds busy high; the store needs no clearing. Results are strobed one
// cycle on out_valid and cannot be stalled; busy is high from acceptance until
// the strobe cycle, which starts with busy low.
module keyed_deque_table_core #(
  parameter int DEPTH = kdt_pkg::DEPTH_DEF,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  in_action,
  input  logic [kdt_pkg::KEY_W-1:0]   in_key,
  input  logic [kdt_pkg::PRICE_W-1:0] in_price,
  input  logic signed [kdt_pkg::QTY_W-1:0] in_quantity,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [kdt_pkg::KEY_W-1:0]   out_entry_key,
  output logic [kdt_pkg::PRICE_W-1:0] out_entry_price,
  output logic signed [kdt_pkg::QTY_W-1:0] out_entry_quantity,
  output logic [kdt_pkg::COUNT_W-1:0] out_entry_count
);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = kdt_pkg::KEY_W;
  localparam int PW = kdt_pkg::PRICE_W;
  localparam int QW = kdt_pkg::QTY_W;
  localparam int EW = kdt_pkg::ENTRY_W;

  typedef enum logic [2:0] {S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN_CMP, S_MOVE_RD,
                            S_MOVE_WR, S_POP_RD, S_DONE} state_t;

  state_t          state_r;
  logic [AW-1:0]   head_r;
  logic [CW-1:0]   count_r;
  logic [KW-1:0]   next_key_r;
  logic [CW-1:0]   pos_r;
  logic [2:0]      act_r;
  logic [KW-1:0]   key_r;
  logic [PW-1:0]   price_r;
  logic [QW-1:0]   qty_r;
  logic            mem_wr;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [EW-1:0]   mem_wdata, mem_rdata;
  logic [AW-1:0]   pos_slot, nxt_slot;

  // ring adder function: logical position to physical slot
  function automatic logic [AW-1:0] ring(input logic [AW-1:0] h, input logic [CW-1:0] p);
    logic [AW:0] s;
    s = {1'b0, h} + (AW+1)'(p);
    if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  assign pos_slot = ring(head_r, pos_r);
  assign nxt_slot = ring(head_r, pos_r + CW'(1));

  always_comb begin
    mem_wr    = 1'b0;
    mem_waddr = pos_slot;
    mem_wdata = mem_rdata;
    mem_raddr = pos_slot;
    case (state_r)
      S_DISPATCH: begin
        if (act_r == kdt_pkg::ACT_PUSH_BACK || act_r == kdt_pkg::ACT_PUSH_FRONT) begin
          mem_wr    = (count_r < CW'(DEPTH));
          mem_wdata = {next_key_r, price_r, qty_r};
        end
      end
      S_SCAN_CMP: begin
        mem_wr    = (act_r == kdt_pkg::ACT_UPDATE) && (mem_rdata[EW-1 -: KW] == key_r);
        mem_wdata = {mem_rdata[EW-1 -: KW], price_r, qty_r};
      end
      S_MOVE_RD: mem_raddr = nxt_slot;
      S_MOVE_WR: mem_wr = 1'b1;
      default: ;
    endcase
  end

  kdt_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk(clk), .wr_en(mem_wr), .wr_addr(mem_waddr), .wr_data(mem_wdata),
    .rd_addr(mem_raddr), .rd_data(mem_rdata)
  );

  assign busy = (state_r != S_IDLE) || !rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      head_r     <= '0;
      count_r    <= '0;
      next_key_r <= KW'(1);
      out_valid  <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        S_IDLE: if (start) begin
          act_r   <= in_action;
          key_r   <= in_key;
          price_r <= in_price;
          qty_r   <= in_quantity;
          state_r <= S_DISPATCH;
          // push front lands at head-1 (at head when empty), push back at count
          if (in_action == kdt_pkg::ACT_PUSH_FRONT)
            pos_r <= (count_r == CW'(0)) ? '0 : CW'(DEPTH - 1);
          else if (in_action == kdt_pkg::ACT_PUSH_BACK) pos_r <= count_r;
          else if (in_action == kdt_pkg::ACT_POP_BACK) pos_r <= count_r - CW'(1);
          else pos_r <= '0;
        end
        S_DISPATCH: begin
          out_status <= kdt_pkg::ST_NONE;
          out_entry_key <= '0;
          out_entry_price <= '0;
          out_entry_quantity <= '0;
          out_entry_count <= kdt_pkg::COUNT_W'(count_r);
          state_r <= S_DONE;
          case (act_r)
            kdt_pkg::ACT_PUSH_BACK, kdt_pkg::ACT_PUSH_FRONT: begin
              if (count_r >= CW'(DEPTH)) begin
                out_status <= kdt_pkg::ST_FULL;
              end else begin
                out_status <= kdt_pkg::ST_OK;
                out_entry_key <= next_key_r;
                out_entry_price <= price_r;
                out_entry_quantity <= qty_r;
                out_entry_count <= kdt_pkg::COUNT_W'(count_r + CW'(1));
                count_r <= count_r + CW'(1);
                next_key_r <= (next_key_r == '1) ? KW'(1) : next_key_r + KW'(1);
                if (act_r == kdt_pkg::ACT_PUSH_FRONT) head_r <= pos_slot;
              end
            end
            kdt_pkg::ACT_POP_FRONT, kdt_pkg::ACT_POP_BACK:
              if (count_r != '0) state_r <= S_POP_RD;
            kdt_pkg::ACT_FIND, kdt_pkg::ACT_REMOVE, kdt_pkg::ACT_UPDATE:
              if (count_r != '0) state_r <= S_SCAN_RD;
            default: ;
          endcase
        end
        S_POP_RD: begin
          state_r <= S_SCAN_CMP;
        end
        S_SCAN_RD: state_r <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (act_r == kdt_pkg::ACT_POP_FRONT || act_r == kdt_pkg::ACT_POP_BACK) begin
            out_status <= kdt_pkg::ST_OK;
            {out_entry_key, out_entry_price, out_entry_quantity} <= mem_rdata;
            out_entry_count <= kdt_pkg::COUNT_W'(count_r - CW'(1));
            count_r <= count_r - CW'(1);
            if (act_r == kdt_pkg::ACT_POP_FRONT) head_r <= ring(head_r, CW'(1));
            state_r <= S_DONE;
          end else if (mem_rdata[EW-1 -: KW] == key_r) begin
            out_status <= kdt_pkg::ST_OK;
            out_entry_key <= mem_rdata[EW-1 -: KW];
            if (act_r == kdt_pkg::ACT_UPDATE) begin
              out_entry_price <= price_r;
              out_entry_quantity <= qty_r;
            end else begin
              out_entry_price <= mem_rdata[QW +: PW];
              out_entry_quantity <= mem_rdata[QW-1:0];
            end
            if (act_r == kdt_pkg::ACT_REMOVE) begin
              out_entry_count <= kdt_pkg::COUNT_W'(count_r - CW'(1));
              state_r <= (pos_r + CW'(1) < count_r) ? S_MOVE_RD : S_DONE;
              if (pos_r + CW'(1) >= count_r) count_r <= count_r - CW'(1);
            end else begin
              state_r <= S_DONE;
            end
          end else if (pos_r + CW'(1) < count_r) begin
            pos_r <= pos_r + CW'(1);
            state_r <= S_SCAN_RD;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_MOVE_RD: state_r <= S_MOVE_WR;
        S_MOVE_WR: begin
          // slot pos takes the entry behind it; advance the gap
          if (pos_r + CW'(2) < count_r) begin
            pos_r <= pos_r + CW'(1);
            state_r <= S_MOVE_RD;
          end else begin
            count_r <= count_r - CW'(1);
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("count over depth");
  a_key_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    next_key_r != '0) else $error("key counter hit zero");
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_hold_used: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE_WR) |-> $past(state_r == S_MOVE_RD))
    else $error("move write without read");
endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  localparam int DEPTH = kdt_pkg::DEPTH_DEF;
  localparam int STALL_LIMIT = 4 * DEPTH * 4 + 200;
  localparam int KEY_W = kdt_pkg::KEY_W;
  localparam int PRICE_W = kdt_pkg::PRICE_W;
  localparam int QTY_W = kdt_pkg::QTY_W;
  localparam int COUNT_W = kdt_pkg::COUNT_W;
  localparam logic [2:0] ACT_ILLEGAL = 3'd7;

  typedef struct {
    logic [1:0]         status;
    logic [KEY_W-1:0]   key;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [COUNT_W-1:0] count;
  } table_reply_t;

  // Mirror of the ordered table; index 0 is the front entry.
  class table_scoreboard;
    logic [KEY_W-1:0]   keys[$];
    logic [PRICE_W-1:0] prices[$];
    logic [QTY_W-1:0]   qtys[$];
    logic [KEY_W-1:0]   key_ctr;
    table_reply_t       pending[$];
    int                 mismatches;

    function new();
      key_ctr = 16'd1;
      mismatches = 0;
    endfunction

    function int locate(logic [KEY_W-1:0] k);
      foreach (keys[i]) if (keys[i] == k) return i;
      return -1;
    endfunction

    function void note_command(logic [2:0] act, logic [KEY_W-1:0] k,
                               logic [PRICE_W-1:0] p, logic [QTY_W-1:0] q);
      table_reply_t r;
      int pos;
      r = '{kdt_pkg::ST_NONE, '0, '0, '0, '0};
      case (act)
        kdt_pkg::ACT_PUSH_BACK, kdt_pkg::ACT_PUSH_FRONT: begin
          if (keys.size() >= DEPTH) r.status = kdt_pkg::ST_FULL;
          else begin
            r = '{kdt_pkg::ST_OK, key_ctr, p, q, '0};
            if (act == kdt_pkg::ACT_PUSH_BACK) begin
              keys.push_back(key_ctr); prices.push_back(p); qtys.push_back(q);
            end else begin
              keys.push_front(key_ctr); prices.push_front(p); qtys.push_front(q);
            end
            key_ctr = (key_ctr == 16'hFFFF) ? 16'd1 : key_ctr + 16'd1;
          end
        end
        kdt_pkg::ACT_POP_FRONT: if (keys.size() > 0)
          r = '{kdt_pkg::ST_OK, keys.pop_front(), prices.pop_front(), qtys.pop_front(), '0};
        kdt_pkg::ACT_POP_BACK: if (keys.size() > 0)
          r = '{kdt_pkg::ST_OK, keys.pop_back(), prices.pop_back(), qtys.pop_back(), '0};
        kdt_pkg::ACT_FIND, kdt_pkg::ACT_REMOVE, kdt_pkg::ACT_UPDATE: begin
          pos = locate(k);
          if (pos >= 0) begin
            if (act == kdt_pkg::ACT_UPDATE) begin
              prices[pos] = p; qtys[pos] = q;
            end
            r = '{kdt_pkg::ST_OK, keys[pos], prices[pos], qtys[pos], '0};
            if (act == kdt_pkg::ACT_REMOVE) begin
              keys.delete(pos); prices.delete(pos); qtys.delete(pos);
            end
          end
        end
        default: ;
      endcase
      r.count = COUNT_W'(keys.size());
      pending.push_back(r);
    endfunction

    function void check_reply(table_reply_t a);
      table_reply_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat key=%0d", a.key);
        return;
      end
      e = pending.pop_front();
      if (a.status !== e.status || a.key !== e.key || a.price !== e.price ||
          a.qty !== e.qty || a.count !== e.count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch exp st=%0d k=%0d p=%0d q=%0d c=%0d got st=%0d k=%0d p=%0d q=%0d c=%0d",
                   e.status, e.key, e.price, $signed(e.qty), e.count,
                   a.status, a.key, a.price, $signed(a.qty), a.count);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [2:0] in_action = '0;
  logic [KEY_W-1:0] in_key = '0;
  logic [PRICE_W-1:0] in_price = '0;
  logic signed [QTY_W-1:0] in_quantity = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic [KEY_W-1:0] out_entry_key;
  logic [PRICE_W-1:0] out_entry_price;
  logic signed [QTY_W-1:0] out_entry_quantity;
  logic [COUNT_W-1:0] out_entry_count;

  table_scoreboard sb = new();
  int idle_cycles = 0;
  int burst_left = 0;

  always #2 clk = ~clk;

  keyed_deque_table_core uut (.*);

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_reply('{out_status, out_entry_key, out_entry_price,
                       out_entry_quantity, out_entry_count});
    if (rst_n && ((start && !busy) || out_valid)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Drive one command and hold it until accepted; gaps may come between bursts.
  task automatic issue(logic [2:0] act, logic [KEY_W-1:0] k,
                       logic [PRICE_W-1:0] p, logic [QTY_W-1:0] q);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    in_action <= act; in_key <= k; in_price <= p; in_quantity <= q;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(act, k, p, q);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if (sb.keys.size() > 0 && $urandom_range(0, 3) != 0)
      return sb.keys[$urandom_range(0, sb.keys.size() - 1)];
    return $urandom_range(0, 3) == 0 ? 16'hFFFF : KEY_W'($urandom);
  endfunction

  initial begin
    int n;
    logic [2:0] act;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // empty table edge cases, then pushes, lookups and pops on a small table
    issue(kdt_pkg::ACT_POP_FRONT, '0, '0, '0);
    issue(kdt_pkg::ACT_POP_BACK, '0, '0, '0);
    issue(kdt_pkg::ACT_FIND, 16'd1, '0, '0);
    issue(kdt_pkg::ACT_REMOVE, 16'd1, '0, '0);
    issue(kdt_pkg::ACT_UPDATE, 16'd1, '0, '0);
    issue(ACT_ILLEGAL, 16'hFFFF, 24'hFFFFFF, 32'hFFFFFFFF);
    issue(kdt_pkg::ACT_PUSH_FRONT, '0, 24'hFFFFFF, 32'h80000000);
    issue(kdt_pkg::ACT_PUSH_BACK, '0, '0, 32'h7FFFFFFF);
    issue(kdt_pkg::ACT_PUSH_FRONT, '0, 24'h123456, 32'hFFFFFFFF);
    issue(kdt_pkg::ACT_FIND, 16'd2, '0, '0);
    issue(kdt_pkg::ACT_UPDATE, 16'd3, 24'hABCDEF, 32'h12345678);
    issue(kdt_pkg::ACT_REMOVE, 16'd1, '0, '0);
    issue(kdt_pkg::ACT_FIND, 16'hFFFF, '0, '0);
    issue(kdt_pkg::ACT_POP_BACK, '0, '0, '0);
    issue(kdt_pkg::ACT_POP_FRONT, '0, '0, '0);
    issue(kdt_pkg::ACT_POP_FRONT, '0, '0, '0);
    // fill to full, overflow both ends, then drain a little
    for (int i = 0; i < DEPTH; i++)
      issue(3'($urandom_range(0, 1)), '0, PRICE_W'($urandom), QTY_W'($urandom));
    issue(kdt_pkg::ACT_PUSH_BACK, '0, 24'd1, 32'd1);
    issue(kdt_pkg::ACT_PUSH_FRONT, '0, 24'd1, 32'd1);
    issue(kdt_pkg::ACT_REMOVE, sb.keys[DEPTH/2], '0, '0);
    // random mix, biased to keep a working set
    n = 0;
    while (n < 400) begin
      case ($urandom_range(0, 9))
        0, 1: act = kdt_pkg::ACT_PUSH_BACK;
        2: act = kdt_pkg::ACT_PUSH_FRONT;
        3: act = kdt_pkg::ACT_POP_FRONT;
        4: act = kdt_pkg::ACT_POP_BACK;
        5, 6: act = kdt_pkg::ACT_FIND;
        7: act = kdt_pkg::ACT_REMOVE;
        8: act = kdt_pkg::ACT_UPDATE;
        default: act = $urandom_range(0, 19) == 0 ? ACT_ILLEGAL : kdt_pkg::ACT_UPDATE;
      endcase
      issue(act, pick_key(), PRICE_W'($urandom), QTY_W'($urandom));
      if (act != ACT_ILLEGAL) n++;
    end
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
